### rtl/iba_pkg.sv
package iba_pkg;

    localparam int MAX_GROUPS      = 8;
    localparam int MAX_PER_GROUP   = 256;
    localparam int WORD_W          = 32;
    localparam int WORDS_PER_GROUP = MAX_PER_GROUP / WORD_W;
    localparam int WORDS           = MAX_GROUPS * WORDS_PER_GROUP;

    localparam int GRP_W  = $clog2(MAX_GROUPS);
    localparam int WSEL_W = $clog2(WORDS_PER_GROUP);
    localparam int BIT_W  = $clog2(WORD_W);
    localparam int ADDR_W = GRP_W + WSEL_W;

    localparam int OP_W   = 2;
    localparam int NUM_W  = 12;
    localparam int ST_W   = 2;
    localparam int GC_W   = 4;
    localparam int IPG_W  = 9;
    localparam int CNT_W  = 9;
    localparam int TOT_W  = 12;
    localparam int CIDX_W = 2;
    localparam int CDAT_W = 9;

    localparam logic [CIDX_W-1:0] CFG_MOUNTED     = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_GROUP_COUNT = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_PER_GROUP   = 2'd2;

    localparam logic [GC_W-1:0]  GC_MAX  = GC_W'(MAX_GROUPS);
    localparam logic [IPG_W-1:0] IPG_MAX = IPG_W'(MAX_PER_GROUP);
    localparam logic [CNT_W-1:0] CNT_SAT = '1;
    localparam logic [TOT_W-1:0] TOT_SAT = '1;

    localparam logic [GC_W-1:0]  GC_RESET  = 4'd1;
    localparam logic [IPG_W-1:0] IPG_RESET = 9'd256;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_FORMAT = 2'd2,
        OP_RSVD   = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNMOUNTED = 2'd1,
        ST_BAD       = 2'd2,
        ST_NONE      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_DIV,
        S_FREE_RD,
        S_FREE_WR,
        S_FORMAT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic    load;
        logic    scan_step;
        logic    alloc_commit;
        logic    div_step;
        logic    free_rd;
        logic    free_commit;
        logic    format;
        logic    finish;
        t_status code;
    } t_cmd;

    typedef struct packed {
        logic mounted;
        t_op  op;
        logic scan_found;
        logic scan_empty;
        logic div_done;
        logic div_bad;
    } t_sts;

endpackage

### rtl/iba_ram.sv
module iba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/iba_ctrl.sv
module iba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  iba_pkg::t_sts i_sts,
    output iba_pkg::t_cmd o_cmd
);
    import iba_pkg::*;

    t_state  r_state, n_state;
    t_status r_code, n_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        o_cmd   = '0;
        o_cmd.code = r_code;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!i_sts.mounted) begin
                    n_code  = ST_UNMOUNTED;
                    n_state = S_FINISH;
                end else begin
                    unique case (i_sts.op)
                        OP_ALLOC:  n_state = S_SCAN;
                        OP_FREE:   n_state = S_DIV;
                        OP_FORMAT: n_state = S_FORMAT;
                        default: begin
                            n_code  = ST_BAD;
                            n_state = S_FINISH;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (i_sts.scan_found) begin
                    o_cmd.alloc_commit = 1'b1;
                    n_code  = ST_OK;
                    n_state = S_FINISH;
                end else if (i_sts.scan_empty) begin
                    n_code  = ST_NONE;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_DIV: begin
                if (i_sts.div_bad) begin
                    n_code  = ST_BAD;
                    n_state = S_FINISH;
                end else if (i_sts.div_done) begin
                    n_state = S_FREE_RD;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_FREE_RD: begin
                o_cmd.free_rd = 1'b1;
                n_state = S_FREE_WR;
            end
            S_FREE_WR: begin
                o_cmd.free_commit = 1'b1;
                n_code  = ST_OK;
                n_state = S_FINISH;
            end
            S_FORMAT: begin
                o_cmd.format = 1'b1;
                n_code  = ST_OK;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

### rtl/iba_datapath.sv
module iba_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [iba_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [iba_pkg::CDAT_W-1:0]   i_cfg_data,
    input  logic [iba_pkg::OP_W-1:0]     i_operation,
    input  logic [iba_pkg::NUM_W-1:0]    i_object_number,
    input  iba_pkg::t_cmd                i_cmd,
    output iba_pkg::t_sts                o_sts,
    output logic                         o_done,
    output logic [iba_pkg::ST_W-1:0]     o_status,
    output logic [iba_pkg::NUM_W-1:0]    o_allocated_number,
    output logic [iba_pkg::TOT_W-1:0]    o_free_total
);
    import iba_pkg::*;

    // configuration
    logic             r_mounted;
    logic [GC_W-1:0]  r_gc;
    logic [IPG_W-1:0] r_ipg;
    logic [GC_W-1:0]  gc_eff;
    logic [IPG_W-1:0] ipg_eff;

    // counts and per-word valid bits (an invalid word reads as all free)
    logic [CNT_W-1:0] r_gcnt [MAX_GROUPS];
    logic [TOT_W-1:0] r_total;
    logic [WORDS-1:0] r_wvalid;

    // latched item
    t_op              r_op;
    logic             r_num_zero;

    // scan
    logic [GC_W-1:0]   r_scan_g;
    logic [WSEL_W-1:0] r_scan_w;
    logic              r_chk_vld;
    logic [ADDR_W-1:0] r_chk_addr;
    logic              scan_live;
    logic [GRP_W-1:0]  scan_g;
    logic              word_in;
    logic              issue;
    logic [GRP_W-1:0]  chk_g;
    logic [WSEL_W-1:0] chk_w;
    logic [IPG_W-1:0]  lim;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] wdat;
    logic [WORD_W-1:0] avail;
    logic [BIT_W-1:0]  pos;
    logic [NUM_W-1:0]  alloc_num;
    logic [NUM_W-1:0]  r_alloc_num;

    // free group search by repeated subtraction
    logic [NUM_W-1:0]  r_div_rem;
    logic [GC_W-1:0]   r_div_g;
    logic              div_fit;
    logic              div_bad;
    logic [ADDR_W-1:0] free_addr;
    logic [GRP_W-1:0]  free_g;
    logic [BIT_W-1:0]  free_bit;

    // memory port
    logic              rd_wv;
    logic              r_rd_wv;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    // result
    logic              r_done;
    t_status           r_status;
    logic [NUM_W-1:0]  r_out_num;
    logic [TOT_W-1:0]  r_out_total;

    assign gc_eff  = (r_gc > GC_MAX) ? GC_MAX : r_gc;
    assign ipg_eff = (r_ipg > IPG_MAX) ? IPG_MAX : r_ipg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mounted <= 1'b0;
            r_gc      <= GC_RESET;
            r_ipg     <= IPG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MOUNTED:     r_mounted <= i_cfg_data[0];
                CFG_GROUP_COUNT: r_gc      <= i_cfg_data[GC_W-1:0];
                CFG_PER_GROUP:   r_ipg     <= i_cfg_data[IPG_W-1:0];
                default: ;
            endcase
        end
    end

    // scan issue side
    assign scan_live = (r_scan_g < gc_eff);
    assign scan_g    = r_scan_g[GRP_W-1:0];
    assign word_in   = (IPG_W'({r_scan_w, {BIT_W{1'b0}}}) < ipg_eff);
    assign issue     = i_cmd.scan_step && scan_live && (r_gcnt[scan_g] != '0) && word_in;

    // scan check side, one word behind the issue side
    assign chk_g = r_chk_addr[ADDR_W-1:WSEL_W];
    assign chk_w = r_chk_addr[WSEL_W-1:0];
    assign wdat  = r_rd_wv ? ram_rdata : '0;
    assign lim   = ipg_eff - IPG_W'({chk_w, {BIT_W{1'b0}}});
    assign mask  = (lim >= IPG_W'(WORD_W)) ? '1 : ~({WORD_W{1'b1}} << lim[BIT_W-1:0]);
    assign avail = ~wdat & mask;

    always_comb begin
        pos = '0;
        for (int k = WORD_W - 1; k >= 0; k--) begin
            if (avail[k]) pos = BIT_W'(k);
        end
    end

    assign alloc_num = NUM_W'(chk_g) * NUM_W'(ipg_eff)
                     + NUM_W'({chk_w, pos}) + NUM_W'(1);

    assign div_fit = (r_div_rem < NUM_W'(ipg_eff));
    assign div_bad = r_num_zero || (ipg_eff == '0) || (gc_eff == '0)
                   || (!div_fit && (GC_W'(r_div_g + 1'b1) >= gc_eff));
    assign free_g    = r_div_g[GRP_W-1:0];
    assign free_addr = {free_g, r_div_rem[BIT_W+WSEL_W-1:BIT_W]};
    assign free_bit  = r_div_rem[BIT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_vld <= 1'b0;
        end else if (i_cmd.load) begin
            r_chk_vld <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_chk_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= t_op'(i_operation);
            r_num_zero  <= (i_object_number == '0);
            r_div_rem   <= i_object_number - NUM_W'(1);
            r_div_g     <= '0;
            r_scan_g    <= '0;
            r_scan_w    <= '0;
            r_alloc_num <= '0;
        end else begin
            if (i_cmd.scan_step && scan_live) begin
                if (issue && (r_scan_w != WSEL_W'(WORDS_PER_GROUP - 1))) begin
                    r_scan_w <= r_scan_w + 1'b1;
                end else begin
                    r_scan_g <= r_scan_g + 1'b1;
                    r_scan_w <= '0;
                end
            end
            if (i_cmd.div_step) begin
                r_div_rem <= r_div_rem - NUM_W'(ipg_eff);
                r_div_g   <= r_div_g + 1'b1;
            end
            if (i_cmd.alloc_commit) begin
                r_alloc_num <= alloc_num;
            end
        end
        if (issue) begin
            r_chk_addr <= {scan_g, r_scan_w};
        end
    end

    // memory access
    assign ram_re    = issue || i_cmd.free_rd;
    assign ram_raddr = issue ? {scan_g, r_scan_w} : free_addr;
    assign rd_wv     = r_wvalid[ram_raddr];
    assign ram_we    = i_cmd.alloc_commit || i_cmd.free_commit;
    assign ram_waddr = i_cmd.alloc_commit ? r_chk_addr : free_addr;
    assign ram_wdata = i_cmd.alloc_commit ? (wdat | (WORD_W'(1) << pos))
                                          : (wdat & ~(WORD_W'(1) << free_bit));

    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_rd_wv <= rd_wv;
        end
    end

    iba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid <= '0;
            r_total  <= '0;
            for (int g = 0; g < MAX_GROUPS; g++) begin
                r_gcnt[g] <= '0;
            end
        end else if (i_cmd.format) begin
            r_wvalid <= '0;
            r_total  <= TOT_W'(gc_eff) * TOT_W'(ipg_eff);
            for (int g = 0; g < MAX_GROUPS; g++) begin
                r_gcnt[g] <= (GC_W'(g) < gc_eff) ? CNT_W'(ipg_eff) : '0;
            end
        end else if (i_cmd.alloc_commit) begin
            r_wvalid[r_chk_addr] <= 1'b1;
            if (r_total != '0) r_total <= r_total - 1'b1;
            if (r_gcnt[chk_g] != '0) r_gcnt[chk_g] <= r_gcnt[chk_g] - 1'b1;
        end else if (i_cmd.free_commit) begin
            r_wvalid[free_addr] <= 1'b1;
            if (r_total != TOT_SAT) r_total <= r_total + 1'b1;
            if (r_gcnt[free_g] != CNT_SAT) r_gcnt[free_g] <= r_gcnt[free_g] + 1'b1;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_status    <= i_cmd.code;
            r_out_num   <= r_alloc_num;
            r_out_total <= r_total;
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.mounted    = r_mounted;
        o_sts.op         = r_op;
        o_sts.scan_found = r_chk_vld && (avail != '0);
        o_sts.scan_empty = !r_chk_vld && !scan_live;
        o_sts.div_done   = !div_bad && div_fit;
        o_sts.div_bad    = div_bad;
    end

    assign o_done             = r_done;
    assign o_status           = r_status;
    assign o_allocated_number = r_out_num;
    assign o_free_total       = r_out_total;

endmodule

### rtl/inode_bitmap_allocator.sv
// an item passes IDLE, DISPATCH and FINISH. unmounted and reserved-code items go
// straight to FINISH; format passes FORMAT; free steps over groups, then reads and
// rewrites the bitmap word; allocate reads a 32-bit bitmap word per cycle, skipping
// zero-count groups. one item at a time; busy is low again with the strobe.
// reset clears counts and bitmap valid bits (no sweep) and resets the configuration.
// results cannot be stalled; each is shown for one cycle on o_done.
module inode_bitmap_allocator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [iba_pkg::OP_W-1:0]     i_operation,
    input  logic [iba_pkg::NUM_W-1:0]    i_object_number,
    output logic                         o_done,
    output logic [iba_pkg::ST_W-1:0]     o_status,
    output logic [iba_pkg::NUM_W-1:0]    o_allocated_number,
    output logic [iba_pkg::TOT_W-1:0]    o_free_total,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [iba_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [iba_pkg::CDAT_W-1:0]   i_cfg_data
);
    import iba_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    iba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    iba_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_operation        (i_operation),
        .i_object_number    (i_object_number),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .o_done             (o_done),
        .o_status           (o_status),
        .o_allocated_number (o_allocated_number),
        .o_free_total       (o_free_total)
    );

endmodule

### rtl/iba_checker.sv
module iba_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      o_done,
    input logic [iba_pkg::ST_W-1:0]  o_status,
    input logic [iba_pkg::NUM_W-1:0] o_allocated_number
);
    import iba_pkg::*;

    // a word only comes out of an item in flight
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without an item in flight");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while still busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_num_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ST_OK)) |-> (o_allocated_number == '0))
        else $error("number given on a failed operation");

endmodule

bind inode_bitmap_allocator iba_checker u_iba_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .start              (start),
    .busy               (busy),
    .o_done             (o_done),
    .o_status           (o_status),
    .o_allocated_number (o_allocated_number)
);

### tb/sv/tb_inode_bitmap_allocator.sv
`timescale 1ns / 1ps

module tb_inode_bitmap_allocator;

    import iba_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 80;
    localparam int N_DIRECTED  = 32;
    localparam int N_PHASES    = 13;
    localparam int SAT_PHASE   = 6;
    localparam int QUIET_PHASE = 3;

    typedef struct packed {
        t_status          st;
        logic [NUM_W-1:0] given;
        logic [TOT_W-1:0] total;
    } t_res;

    typedef struct packed {
        logic              is_cfg;
        logic [CIDX_W-1:0] cidx;
        logic [CDAT_W-1:0] cdata;
        t_op               op;
        logic [NUM_W-1:0]  num;
        logic              chk;
        t_res              want;
    } t_dir_row;

    localparam t_res NO_RES = '{ST_OK, 12'd0, 12'd0};

    // fixed results only where they follow directly from the counts
    localparam t_dir_row DIR_TAB [N_DIRECTED] = '{
        '{1'b0, CFG_MOUNTED, 9'd0, OP_ALLOC, 12'd0, 1'b1, '{ST_UNMOUNTED, 12'd0, 12'd0}},
        '{1'b0, CFG_MOUNTED, 9'd0, OP_FORMAT, 12'd0, 1'b1, '{ST_UNMOUNTED, 12'd0, 12'd0}},
        '{1'b0, CFG_MOUNTED, 9'd0, OP_FREE, 12'd1, 1'b1, '{ST_UNMOUNTED, 12'd0, 12'd0}},
        '{1'b1, CFG_MOUNTED, 9'd1, OP_ALLOC, 12'd0, 1'b0, NO_RES},
        '{1'b0, CFG_MOUNTED, 9'd0, OP_ALLOC, 12'd0, 1'b1, '{ST_NONE, 12'd0, 12'd0}},
        '{1'b0, CFG_MOUNTED, 9'd0, OP_FREE, 12'd1, 1'b1, '{ST_OK, 12'd0, 12'd1}},
        '{1'b0, CFG_MOUNTED, 9'd0, OP_ALLOC, 12'd0, 1'b1, '{ST_OK, 12'd1, 12'd0}},
        '{1'b0, CFG_MOUNTED, 9'd0, OP_FREE, 12'd0, 1'b1, '{ST_BAD, 12'd0, 12'd0}},
        '{1'b0, CFG_MOUNTED, 9'd0, OP_RSVD, 12'hFFF, 1'b1, '{ST_BAD, 12'd0, 12'd0}},
        '{1'b0, CFG_MOUNTED, 9'd0, OP_FREE, 12'd257, 1'b1, '{ST_BAD, 12'd0, 12'd0}},
        '{1'b1, CFG_GROUP_COUNT, 9'd8, OP_ALLOC, 12'd0, 1'b0, NO_RES},
        '{1'b1, CFG_PER_GROUP, 9'd256, OP_ALLOC, 12'd0, 1'b0, NO_RES},
        '{1'b0, CFG_MOUNTED, 9'd0, OP_FORMAT, 12'd0, 1'b1, '{ST_OK, 12'd0, 12'd2048}},
        '{1'b0, CFG_MOUNTED, 9'd0, OP_ALLOC, 12'hFFF, 1'b1, '{ST_OK, 12'd1, 12'd2047}},
        // freeing a bit that is already clear still bumps the counts
        '{1'b0, CFG_MOUNTED, 9'd0, OP_FREE, 12'd2048, 1'b1, '{ST_OK, 12'd0, 12'd2048}},
        '{1'b0, CFG_MOUNTED, 9'd0, OP_FREE, 12'd2049, 1'b1, '{ST_BAD, 12'd0, 12'd2048}},
        '{1'b0, CFG_MOUNTED, 9'd0, OP_FREE, 12'hFFF, 1'b1, '{ST_BAD, 12'd0, 12'd2048}},
        '{1'b1, CFG_PER_GROUP, 9'd1, OP_ALLOC, 12'd0, 1'b0, NO_RES},
        // group 0 has a nonzero count but a full bitmap
        '{1'b0, CFG_MOUNTED, 9'd0, OP_ALLOC, 12'd0, 1'b0, NO_RES},
        '{1'b0, CFG_MOUNTED, 9'd0, OP_FORMAT, 12'd0, 1'b1, '{ST_OK, 12'd0, 12'd8}},
        '{1'b0, CFG_MOUNTED, 9'd0, OP_ALLOC, 12'd0, 1'b1, '{ST_OK, 12'd1, 12'd7}},
        '{1'b1, CFG_PER_GROUP, 9'd0, OP_ALLOC, 12'd0, 1'b0, NO_RES},
        '{1'b0, CFG_MOUNTED, 9'd0, OP_ALLOC, 12'd0, 1'b1, '{ST_NONE, 12'd0, 12'd7}},
        '{1'b0, CFG_MOUNTED, 9'd0, OP_FREE, 12'd1, 1'b1, '{ST_BAD, 12'd0, 12'd7}},
        '{1'b1, CFG_PER_GROUP, 9'd511, OP_ALLOC, 12'd0, 1'b0, NO_RES},
        '{1'b1, CFG_GROUP_COUNT, 9'd15, OP_ALLOC, 12'd0, 1'b0, NO_RES},
        '{1'b0, CFG_MOUNTED, 9'd0, OP_FORMAT, 12'd0, 1'b1, '{ST_OK, 12'd0, 12'd2048}},
        '{1'b1, CFG_GROUP_COUNT, 9'd0, OP_ALLOC, 12'd0, 1'b0, NO_RES},
        '{1'b0, CFG_MOUNTED, 9'd0, OP_ALLOC, 12'd0, 1'b1, '{ST_NONE, 12'd0, 12'd2048}},
        '{1'b0, CFG_MOUNTED, 9'd0, OP_FREE, 12'd1, 1'b1, '{ST_BAD, 12'd0, 12'd2048}},
        '{1'b1, CFG_MOUNTED, 9'd0, OP_ALLOC, 12'd0, 1'b0, NO_RES},
        '{1'b0, CFG_MOUNTED, 9'd0, OP_FORMAT, 12'd0, 1'b1, '{ST_UNMOUNTED, 12'd0, 12'd2048}}
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [OP_W-1:0]    i_operation = '0;
    logic [NUM_W-1:0]   i_object_number = '0;
    logic               o_done;
    logic [ST_W-1:0]    o_status;
    logic [NUM_W-1:0]   o_allocated_number;
    logic [TOT_W-1:0]   o_free_total;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CIDX_W-1:0]  i_cfg_index = '0;
    logic [CDAT_W-1:0]  i_cfg_data = '0;

    inode_bitmap_allocator DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_operation        (i_operation),
        .i_object_number    (i_object_number),
        .o_done             (o_done),
        .o_status           (o_status),
        .o_allocated_number (o_allocated_number),
        .o_free_total       (o_free_total),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow of the allocator state
    logic                      map_mounted = 1'b0;
    logic [GC_W-1:0]           map_groups  = GC_RESET;
    logic [IPG_W-1:0]          map_ipg     = IPG_RESET;
    logic [MAX_PER_GROUP-1:0]  used_map [MAX_GROUPS];
    logic [CNT_W-1:0]          grp_free [MAX_GROUPS];
    logic [TOT_W-1:0]          free_sum = '0;

    t_res pending_outcomes [$];
    int   mismatches = 0;
    int   stall_cycles = 0;
    bit   idle_en = 1'b1;

    function automatic int eff_groups();
        return (int'(map_groups) > MAX_GROUPS) ? MAX_GROUPS : int'(map_groups);
    endfunction

    function automatic int eff_ipg();
        return (int'(map_ipg) > MAX_PER_GROUP) ? MAX_PER_GROUP : int'(map_ipg);
    endfunction

    function automatic t_res bitmap_op_outcome(input t_op op, input logic [NUM_W-1:0] num);
        t_res r;
        int   egc;
        int   eipg;
        int   g;
        int   b;
        int   n;
        int   cap;
        bit   hit;
        r = NO_RES;
        egc = eff_groups();
        eipg = eff_ipg();
        n = int'(num);
        if (!map_mounted) begin
            r.st = ST_UNMOUNTED;
        end else begin
            case (op)
                OP_ALLOC: begin
                    r.st = ST_NONE;
                    hit = 1'b0;
                    for (g = 0; g < egc && !hit; g++) begin
                        if (grp_free[g] != '0) begin
                            for (b = 0; b < eipg && !hit; b++) begin
                                if (!used_map[g][b]) begin
                                    hit = 1'b1;
                                    used_map[g][b] = 1'b1;
                                    if (free_sum != '0) free_sum = free_sum - 1'b1;
                                    grp_free[g] = grp_free[g] - 1'b1;
                                    r.given = NUM_W'(g * eipg + b + 1);
                                    r.st = ST_OK;
                                end
                            end
                        end
                    end
                end
                OP_FREE: begin
                    if (n == 0 || eipg == 0 || (n - 1) / eipg >= egc) begin
                        r.st = ST_BAD;
                    end else begin
                        g = (n - 1) / eipg;
                        used_map[g][(n - 1) % eipg] = 1'b0;
                        if (free_sum != TOT_SAT) free_sum = free_sum + 1'b1;
                        if (grp_free[g] != CNT_SAT) grp_free[g] = grp_free[g] + 1'b1;
                    end
                end
                OP_FORMAT: begin
                    cap = (eipg > int'(CNT_SAT)) ? int'(CNT_SAT) : eipg;
                    for (g = 0; g < MAX_GROUPS; g++) begin
                        used_map[g] = '0;
                        grp_free[g] = (g < egc) ? CNT_W'(cap) : '0;
                    end
                    free_sum = (egc * eipg > int'(TOT_SAT)) ? TOT_SAT : TOT_W'(egc * eipg);
                end
                default: r.st = ST_BAD;
            endcase
        end
        r.total = free_sum;
        return r;
    endfunction

    task automatic idle_gap();
        if (idle_en) begin
            while ($urandom_range(99) < 27) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
    endtask

    // start stays high between back-to-back words
    task automatic issue_op(input t_op op, input logic [NUM_W-1:0] num,
                            input bit chk, input t_res want);
        t_res r;
        i_cfg_valid <= 1'b0;
        idle_gap();
        start           <= 1'b1;
        i_operation     <= op;
        i_object_number <= num;
        do @(posedge i_clk); while (busy);
        r = bitmap_op_outcome(op, num);
        pending_outcomes.push_back(chk ? want : r);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] data);
        start <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MOUNTED:     map_mounted = data[0];
            CFG_GROUP_COUNT: map_groups  = data[GC_W-1:0];
            CFG_PER_GROUP:   map_ipg     = data[IPG_W-1:0];
            default: ;
        endcase
    endtask

    // results are sampled mid-cycle, the strobe lasts the whole cycle
    always @(negedge i_clk) begin
        t_res e;
        if (i_rst_n && o_done) begin
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d number %0d total %0d",
                             o_status, o_allocated_number, o_free_total);
            end else begin
                e = pending_outcomes.pop_front();
                if (o_status !== e.st || o_allocated_number !== e.given ||
                    o_free_total !== e.total) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: status %0d/%0d number %0d/%0d total %0d/%0d",
                                 e.st, o_status, e.given, o_allocated_number,
                                 e.total, o_free_total);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_inode_bitmap_allocator NOT OK");
            $finish;
        end
    end

    initial begin
        int   i;
        int   ph;
        int   k;
        int   n_ops;
        int   gc;
        int   ipg;
        int   cap;
        int   r;
        int   num;
        logic mnt;
        for (i = 0; i < MAX_GROUPS; i++) begin
            used_map[i] = '0;
            grp_free[i] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < N_DIRECTED; i++) begin
            if (DIR_TAB[i].is_cfg)
                write_reg(DIR_TAB[i].cidx, DIR_TAB[i].cdata);
            else
                issue_op(DIR_TAB[i].op, DIR_TAB[i].num, DIR_TAB[i].chk, DIR_TAB[i].want);
        end

        for (ph = 0; ph < N_PHASES; ph++) begin
            idle_en = (ph != QUIET_PHASE && ph != SAT_PHASE);
            if (ph == SAT_PHASE) begin
                // many frees into one group to drive its count to saturation
                mnt = 1'b1;
                gc  = 1;
                ipg = MAX_PER_GROUP;
            end else begin
                mnt = ($urandom_range(9) != 0);
                case ($urandom_range(9))
                    0: gc = 0;
                    1: gc = $urandom_range(15, MAX_GROUPS + 1);
                    2: gc = MAX_GROUPS;
                    3: gc = 1;
                    default: gc = $urandom_range(MAX_GROUPS, 1);
                endcase
                case ($urandom_range(9))
                    0: ipg = 0;
                    1: ipg = $urandom_range(511, MAX_PER_GROUP + 1);
                    2: ipg = MAX_PER_GROUP;
                    3: ipg = 1;
                    default: ipg = $urandom_range(24, 1);
                endcase
            end
            write_reg(CFG_MOUNTED, CDAT_W'(mnt));
            write_reg(CFG_GROUP_COUNT, CDAT_W'(gc));
            write_reg(CFG_PER_GROUP, CDAT_W'(ipg));
            cap = eff_groups() * eff_ipg();
            if (ph == SAT_PHASE || $urandom_range(9) < 8)
                issue_op(OP_FORMAT, NUM_W'($urandom), 1'b0, NO_RES);
            n_ops = (ph == SAT_PHASE) ? 300 : 42;
            for (k = 0; k < n_ops; k++) begin
                r = $urandom_range(99);
                if (r < 75 && cap > 0)
                    num = $urandom_range(cap, 1);
                else if (r < 85)
                    num = ($urandom_range(1) != 0) ? 0 : cap + 1;
                else
                    num = $urandom;
                r = $urandom_range(99);
                if (ph == SAT_PHASE)
                    issue_op((r < 90) ? OP_FREE : OP_ALLOC, NUM_W'(num), 1'b0, NO_RES);
                else if (r < 62)
                    issue_op(OP_ALLOC, NUM_W'(num), 1'b0, NO_RES);
                else if (r < 92)
                    issue_op(OP_FREE, NUM_W'(num), 1'b0, NO_RES);
                else if (r < 97)
                    issue_op(OP_FORMAT, NUM_W'(num), 1'b0, NO_RES);
                else
                    issue_op(OP_RSVD, NUM_W'(num), 1'b0, NO_RES);
            end
        end

        start <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_outcomes.size() == 0)
            $display("tb_inode_bitmap_allocator OK");
        else
            $display("tb_inode_bitmap_allocator NOT OK");
        $finish;
    end

endmodule
